@@ hdl/rpou_pkg.sv @@
// Package for the RGB555 pixel operation unit.
// Holds the word types, operation codes, channel constants and the ordered dither table.
// No dependencies; rpou_chan and the top level refer to it by scoped names.
package rpou_pkg;

	localparam int unsigned CH_W = 5;
	localparam int unsigned NUM_CH = 3;
	localparam int unsigned COLOUR_W = 16;
	localparam int unsigned WEIGHT_W = 5;
	localparam int unsigned AMOUNT_W = 8;
	localparam int unsigned FRAC_SHIFT = 4;

	localparam logic [CH_W-1:0] CH_MAX = 5'd31;
	localparam logic [WEIGHT_W-1:0] FRAC_ONE = 5'd16;
	localparam logic [COLOUR_W-1:0] PX_SET_BIT = 16'h8000;

	typedef enum logic [1:0] {
		KIND_MIX = 2'd0,
		KIND_SHADE = 2'd1,
		KIND_DITHER = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [COLOUR_W-1:0] colour_a;
		logic [COLOUR_W-1:0] colour_b;
		logic [WEIGHT_W-1:0] weight;
		logic [AMOUNT_W-1:0] shade_amount;
		logic [1:0] x_low;
		logic [1:0] y_low;
	} in_word_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] colour_out;
		logic write_enable;
	} out_word_t;

	// Bayer threshold for a 4x4 cell, indexed by row then column.
	function automatic logic [3:0] bayer4(input logic [1:0] y, input logic [1:0] x);
		logic [3:0] t;
		case ({y, x})
			4'd0: t = 4'd0;
			4'd1: t = 4'd8;
			4'd2: t = 4'd2;
			4'd3: t = 4'd10;
			4'd4: t = 4'd12;
			4'd5: t = 4'd4;
			4'd6: t = 4'd14;
			4'd7: t = 4'd6;
			4'd8: t = 4'd3;
			4'd9: t = 4'd11;
			4'd10: t = 4'd1;
			4'd11: t = 4'd9;
			4'd12: t = 4'd15;
			4'd13: t = 4'd7;
			4'd14: t = 4'd13;
			default: t = 4'd5;
		endcase
		return t;
	endfunction

endpackage

@@ hdl/rpou_stream_if.sv @@
// Valid/ready stream interface carrying one word of a given packed type.
// Used for both the pixel input and the result channel; depends on nothing.
interface rpou_stream_if #(parameter type word_t = logic);
	logic valid;
	logic ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/rpou_chan.sv @@
// One 5-bit colour channel: the mix blend and the saturating shade.
// Depends on rpou_pkg for widths and constants.
module rpou_chan (
	input logic [rpou_pkg::CH_W-1:0] a,
	input logic [rpou_pkg::CH_W-1:0] b,
	input logic [rpou_pkg::WEIGHT_W-1:0] weight_sat,
	input logic [rpou_pkg::AMOUNT_W-1:0] amount,
	output logic [rpou_pkg::CH_W-1:0] mix,
	output logic [rpou_pkg::CH_W-1:0] shade
);
	localparam int unsigned MIX_PW = rpou_pkg::CH_W + rpou_pkg::WEIGHT_W;
	localparam int unsigned SHD_PW = rpou_pkg::CH_W + rpou_pkg::AMOUNT_W;

	logic b_ge_a;
	logic [rpou_pkg::CH_W-1:0] diff;
	logic [MIX_PW-1:0] mix_prod;
	logic [rpou_pkg::CH_W-1:0] step;
	logic [SHD_PW-1:0] shd_prod;
	logic [SHD_PW-rpou_pkg::FRAC_SHIFT-1:0] shd_val;

	always_comb begin
		b_ge_a = (b >= a);
		diff = b_ge_a ? (b - a) : (a - b);
		mix_prod = MIX_PW'(diff) * MIX_PW'(weight_sat);
		step = rpou_pkg::CH_W'(mix_prod >> rpou_pkg::FRAC_SHIFT);
		mix = b_ge_a ? (a + step) : (a - step);

		shd_prod = SHD_PW'(a) * SHD_PW'(amount);
		shd_val = shd_prod[SHD_PW-1:rpou_pkg::FRAC_SHIFT];
		if (shd_val > (SHD_PW-rpou_pkg::FRAC_SHIFT)'(rpou_pkg::CH_MAX)) begin
			shade = rpou_pkg::CH_MAX;
		end else begin
			shade = shd_val[rpou_pkg::CH_W-1:0];
		end
	end
endmodule

@@ hdl/rgb555_pixel_operation_unit_top.sv @@
// Top level of the RGB555 pixel operation unit: input register, per-channel
// arithmetic and dither select, result register. Depends on rpou_pkg,
// rpou_stream_if and rpou_chan.
//
// Usage: pixel words arrive on pix_in (valid/ready), each carrying the kind,
// two colours, the weight, the shade amount and the low pixel coordinates.
// Every accepted word produces exactly one result word on pix_out, in order.
// Mix and shade always write and set bit 15; dither writes colour_a when the
// Bayer threshold is below the weight and otherwise returns colour_b with
// write_enable low. The unused kind code behaves like a dither that keeps.
// A word accepted on pix_in is held in the input register and is loaded into
// the result register whenever that register can advance, and one word is
// taken every cycle as long as pix_out is ready. The block has an
// input register and a result register; when the receiver stalls, the result
// holds, the input register still fills, and pix_in drops ready once both
// registers are full. Reset empties both registers; there is no other state.
module rgb555_pixel_operation_unit_top (
	input logic clk,
	input logic arst_n,
	rpou_stream_if.sink pix_in,
	rpou_stream_if.source pix_out
);
	localparam int unsigned CW = rpou_pkg::CH_W;

	logic valid_s1;
	rpou_pkg::in_word_t word_s1;
	logic valid_s2;
	rpou_pkg::out_word_t word_s2;

	logic adv;
	logic [rpou_pkg::WEIGHT_W-1:0] weight_sat;
	logic [CW-1:0] mix_ch [rpou_pkg::NUM_CH];
	logic [CW-1:0] shade_ch [rpou_pkg::NUM_CH];
	logic [3:0] threshold;
	rpou_pkg::out_word_t result;

	assign adv = !valid_s2 || pix_out.ready;
	assign pix_in.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_in.valid && pix_in.ready) begin
			word_s1 <= pix_in.data;
		end
	end

	assign weight_sat = (word_s1.weight > rpou_pkg::FRAC_ONE) ? rpou_pkg::FRAC_ONE
		: word_s1.weight;

	for (genvar k = 0; k < rpou_pkg::NUM_CH; k++) begin : g_chan
		rpou_chan u_chan (
			.a(word_s1.colour_a[k*CW +: CW]),
			.b(word_s1.colour_b[k*CW +: CW]),
			.weight_sat(weight_sat),
			.amount(word_s1.shade_amount),
			.mix(mix_ch[k]),
			.shade(shade_ch[k])
		);
	end

	assign threshold = rpou_pkg::bayer4(word_s1.y_low, word_s1.x_low);

	always_comb begin
		result.colour_out = word_s1.colour_b;
		result.write_enable = 1'b0;
		unique case (rpou_pkg::kind_t'(word_s1.kind))
			rpou_pkg::KIND_MIX: begin
				result.colour_out = rpou_pkg::PX_SET_BIT | {1'b0, mix_ch[2], mix_ch[1], mix_ch[0]};
				result.write_enable = 1'b1;
			end
			rpou_pkg::KIND_SHADE: begin
				result.colour_out = rpou_pkg::PX_SET_BIT
					| {1'b0, shade_ch[2], shade_ch[1], shade_ch[0]};
				result.write_enable = 1'b1;
			end
			rpou_pkg::KIND_DITHER: begin
				if (rpou_pkg::WEIGHT_W'(threshold) < word_s1.weight) begin
					result.colour_out = word_s1.colour_a;
					result.write_enable = 1'b1;
				end
			end
			default: begin
				result.colour_out = word_s1.colour_b;
				result.write_enable = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			word_s2 <= result;
		end
	end

	assign pix_out.valid = valid_s2;
	assign pix_out.data = word_s2;
endmodule
